@@ rtl/udrb_pkg.sv @@
`timescale 1ns / 1ps

package udrb_pkg;

    localparam int QUEUE_DEPTH = 512;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int BYTE_W      = 8;
    localparam int OUT_COUNT_W = 10;

    typedef enum logic [1:0] {
        ACT_HOST_WRITE = 2'd0,
        ACT_HOST_READ  = 2'd1,
        ACT_TX_EMPTY   = 2'd2,
        ACT_RX_FULL    = 2'd3
    } t_action;

    typedef logic [PTR_W-1:0]   t_ptr;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [BYTE_W-1:0]  t_byte;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_req;

    typedef struct packed {
        logic   ok;
        t_count count;
    } t_q_stat;

    function automatic t_ptr advance(input t_ptr p);
        if (p == t_ptr'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + t_ptr'(1);
    endfunction

endpackage

@@ rtl/udrb_ram.sv @@
`timescale 1ns / 1ps

module udrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/udrb_queue.sv @@
`timescale 1ns / 1ps

module udrb_queue
    import udrb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_req  i_req,
    input  t_byte   i_wdata,
    output t_q_stat o_stat,
    output t_byte   o_rdata
);

    t_ptr   r_rd_ptr, n_rd_ptr;
    t_ptr   r_wr_ptr, n_wr_ptr;
    t_count r_count, n_count;
    logic   push_ok;
    logic   pop_ok;

    assign push_ok = i_req.push && (r_count != t_count'(QUEUE_DEPTH));
    assign pop_ok  = i_req.pop && (r_count != '0);

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_ptr = advance(r_wr_ptr);
            n_count  = r_count + t_count'(1);
        end else if (pop_ok) begin
            n_rd_ptr = advance(r_rd_ptr);
            n_count  = r_count - t_count'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    udrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (push_ok),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_wdata),
        .i_re    (pop_ok),
        .i_raddr (r_rd_ptr),
        .o_rdata (o_rdata)
    );

    assign o_stat.ok    = push_ok || pop_ok;
    assign o_stat.count = r_count;

endmodule

@@ rtl/uart_dual_ring_buffer_core.sv @@
`timescale 1ns / 1ps

// Transmit and receive byte queues, each held in its own single-port-write,
// registered-read RAM. The block never asserts o_busy, so a command may be
// issued on every clock and one item completes per cycle. The result of a
// command appears on the cycle after it is accepted, marked by o_valid for
// exactly one cycle; the receiver must take it then, since it cannot stall.
// The result byte is taken from the registered RAM read ports. The count
// outputs always show the queue fill after the most recent command.

module uart_dual_ring_buffer_core
    import udrb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic [1:0]             i_action,
    input  logic [BYTE_W-1:0]      i_data_in,
    output logic                   o_valid,
    output logic [BYTE_W-1:0]      o_data_out,
    output logic                   o_done_res,
    output logic [OUT_COUNT_W-1:0] o_tx_pending,
    output logic [OUT_COUNT_W-1:0] o_tx_free,
    output logic [OUT_COUNT_W-1:0] o_rx_available
);

    logic    accept;
    t_action action;
    t_q_req  tx_req;
    t_q_req  rx_req;
    t_q_stat tx_stat;
    t_q_stat rx_stat;
    t_byte   tx_rdata;
    t_byte   rx_rdata;
    t_count  tx_free;

    logic r_valid;
    logic r_done;
    logic r_pop_tx;
    logic r_pop_rx;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;
    assign action = t_action'(i_action);

    always_comb begin
        tx_req = '0;
        rx_req = '0;
        if (accept) begin
            case (action)
                ACT_HOST_WRITE: tx_req.push = 1'b1;
                ACT_HOST_READ:  rx_req.pop  = 1'b1;
                ACT_TX_EMPTY:   tx_req.pop  = 1'b1;
                ACT_RX_FULL:    rx_req.push = 1'b1;
                default: begin
                    tx_req = '0;
                    rx_req = '0;
                end
            endcase
        end
    end

    udrb_queue u_tx_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tx_req),
        .i_wdata (i_data_in),
        .o_stat  (tx_stat),
        .o_rdata (tx_rdata)
    );

    udrb_queue u_rx_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rx_req),
        .i_wdata (i_data_in),
        .o_stat  (rx_stat),
        .o_rdata (rx_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_done   <= 1'b0;
            r_pop_tx <= 1'b0;
            r_pop_rx <= 1'b0;
        end else begin
            r_valid  <= accept;
            r_done   <= tx_stat.ok || rx_stat.ok;
            r_pop_tx <= tx_req.pop && tx_stat.ok;
            r_pop_rx <= rx_req.pop && rx_stat.ok;
        end
    end

    assign tx_free = t_count'(QUEUE_DEPTH) - tx_stat.count;

    always_comb begin
        o_data_out = '0;
        if (r_pop_tx) begin
            o_data_out = tx_rdata;
        end else if (r_pop_rx) begin
            o_data_out = rx_rdata;
        end
    end

    assign o_valid        = r_valid;
    assign o_done_res     = r_done;
    assign o_tx_pending   = OUT_COUNT_W'(tx_stat.count);
    assign o_tx_free      = OUT_COUNT_W'(tx_free);
    assign o_rx_available = OUT_COUNT_W'(rx_stat.count);

endmodule

@@ rtl/udrb_checker.sv @@
`timescale 1ns / 1ps

module udrb_checker
    import udrb_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_start,
    input logic                   o_busy,
    input logic [1:0]             i_action,
    input logic                   o_valid,
    input logic [BYTE_W-1:0]      o_data_out,
    input logic                   o_done_res,
    input logic [OUT_COUNT_W-1:0] o_tx_pending,
    input logic [OUT_COUNT_W-1:0] o_tx_free,
    input logic [OUT_COUNT_W-1:0] o_rx_available
);

    // Every accepted word yields exactly one result on the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_valid)
        else $error("accepted word produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_start && !o_busy) |=> !o_valid)
        else $error("result without an accepted word");

    a_free_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_tx_pending + o_tx_free) == OUT_COUNT_W'(QUEUE_DEPTH))
        else $error("transmit pending and free do not add up to the depth");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_done_res) |-> (o_data_out == '0))
        else $error("failed command returned a nonzero byte");

    a_write_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_action == ACT_HOST_WRITE) |=>
            (o_done_res ? (o_tx_pending == $past(o_tx_pending) + 1'b1)
                        : (o_tx_pending == $past(o_tx_pending))))
        else $error("transmit count did not follow a host write");

endmodule

bind uart_dual_ring_buffer_core udrb_checker u_udrb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .i_action       (i_action),
    .o_valid        (o_valid),
    .o_data_out     (o_data_out),
    .o_done_res     (o_done_res),
    .o_tx_pending   (o_tx_pending),
    .o_tx_free      (o_tx_free),
    .o_rx_available (o_rx_available)
);
